>>> hw/rtl/lesf_pkg.sv
// Package: constants and types shared by the largest empty square finder.
`timescale 1ns / 1ps
`default_nettype none

package lesf_pkg;

    localparam int MAX_SIDE = 1024;
    localparam int CNT_W    = $clog2(MAX_SIDE);
    localparam int SIDE_W   = 11;
    localparam int CODE_W   = 8;
    localparam int POS_W    = 10;
    localparam int SZ_W     = (CNT_W + 1 > SIDE_W) ? CNT_W + 1 : SIDE_W;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [SIDE_W-1:0] SIDE_RESET  = SIDE_W'(1024);
    localparam logic [CODE_W-1:0] EMPTY_RESET = CODE_W'(46);
    localparam logic [SZ_W-1:0]   SIDE_MAX    = SZ_W'(MAX_SIDE);

    localparam logic REG_GRID_SIDE  = 1'b0;
    localparam logic REG_EMPTY_CODE = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             empty;
        logic             fwd;
        logic             last;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
    } t_cell_stage;

endpackage

`default_nettype wire

>>> hw/rtl/largest_empty_square_finder_top.sv
// Top level: streaming maximal-square search over a grid with a line buffer memory.
//
//  channel   | direction | handshake                        | payload
//  ----------+-----------+----------------------------------+----------------------------------
//  cell_req  | in        | i_cell_req_valid/o_cell_req_ready| i_cell_req[7:0]
//  res       | out       | o_res_valid/i_res_ready          | o_found, o_best_size/row/col
//  apb       | in        | psel/penable/pwrite/pready       | paddr[2:0], pwdata, prdata
//
//  One cell per cycle unless a stall holds the input; a result is registered in the output
//  register after the last cell of a grid leaves stage 1. The cell rate is set by the simple
//  dual-port line buffer: one read and one write each cycle. Synchronous active-low reset
//  clears control state; the line buffer needs no clear. A result held in the output register
//  stalls both stages only when the next result is ready to leave; other cells pass under a full output register.
`timescale 1ns / 1ps
`default_nettype none

module largest_empty_square_finder_top
    import lesf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cell_req_valid,
    output logic                   o_cell_req_ready,
    input  wire logic [CODE_W-1:0] i_cell_req,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output logic                   o_found,
    output logic [SIDE_W-1:0]      o_best_size,
    output logic [POS_W-1:0]       o_best_row,
    output logic [POS_W-1:0]       o_best_col,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic [SIDE_W-1:0] r_grid_side;
    logic [CODE_W-1:0] r_empty_code;

    logic [CNT_W-1:0]  r_row_count;
    logic [CNT_W-1:0]  r_col_count;
    logic [CNT_W-1:0]  n_row_count;
    logic [CNT_W-1:0]  n_col_count;

    t_cell_stage       r_s1;
    t_cell_stage       n_s1;

    logic [SZ_W-1:0]   line_mem [MAX_SIDE];
    logic [SZ_W-1:0]   r_rdata;
    logic [SZ_W-1:0]   r_wval;

    logic [SZ_W-1:0]   r_left_size;
    logic [SZ_W-1:0]   r_diag_size;
    logic [SZ_W-1:0]   r_best_side;
    logic [POS_W-1:0]  r_best_top;
    logic [POS_W-1:0]  r_best_left;
    logic [SZ_W-1:0]   n_best_side;
    logic [POS_W-1:0]  n_best_top;
    logic [POS_W-1:0]  n_best_left;

    logic              r_res_valid;
    logic              r_found;
    logic [SIDE_W-1:0] r_res_size;
    logic [POS_W-1:0]  r_res_row;
    logic [POS_W-1:0]  r_res_col;

    logic [SZ_W-1:0]   side_eff;
    logic              last_col;
    logic              last_row;
    logic              stall;
    logic              accept;
    logic              s1_done;
    logic              cfg_wr;
    logic [SZ_W-1:0]   up;
    logic [SZ_W-1:0]   left;
    logic [SZ_W-1:0]   diag;
    logic [SZ_W-1:0]   min_ul;
    logic [SZ_W-1:0]   min3;
    logic [SZ_W-1:0]   val;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side  <= SIDE_RESET;
            r_empty_code <= EMPTY_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_GRID_SIDE:  r_grid_side  <= pwdata[SIDE_W-1:0];
                REG_EMPTY_CODE: r_empty_code <= pwdata[CODE_W-1:0];
                default:        r_grid_side  <= r_grid_side;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GRID_SIDE:  prdata = APB_DW'(r_grid_side);
            REG_EMPTY_CODE: prdata = APB_DW'(r_empty_code);
            default:        prdata = '0;
        endcase
    end

    // stage 0: position tracking and line buffer read
    assign stall    = r_s1.valid && r_s1.last && r_res_valid && !i_res_ready;
    assign o_cell_req_ready = !stall;
    assign accept   = i_cell_req_valid && o_cell_req_ready;
    assign s1_done  = r_s1.valid && !stall;

    always_comb begin
        if (r_grid_side == '0) begin
            side_eff = SZ_W'(1);
        end else if (SZ_W'(r_grid_side) > SIDE_MAX) begin
            side_eff = SIDE_MAX;
        end else begin
            side_eff = SZ_W'(r_grid_side);
        end
        last_col = (SZ_W'(r_col_count) + SZ_W'(1)) >= side_eff;
        last_row = (SZ_W'(r_row_count) + SZ_W'(1)) >= side_eff;

        n_row_count = r_row_count;
        n_col_count = r_col_count;
        if (accept) begin
            if (last_col && last_row) begin
                n_row_count = '0;
                n_col_count = '0;
            end else if (last_col) begin
                n_row_count = r_row_count + CNT_W'(1);
                n_col_count = '0;
            end else begin
                n_col_count = r_col_count + CNT_W'(1);
            end
        end

        n_s1 = r_s1;
        if (accept) begin
            n_s1.valid = 1'b1;
            n_s1.empty = (i_cell_req == r_empty_code);
            n_s1.fwd   = s1_done && (r_s1.col == r_col_count);
            n_s1.last  = last_col && last_row;
            n_s1.row   = r_row_count;
            n_s1.col   = r_col_count;
        end else if (s1_done) begin
            n_s1.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= '0;
            r_col_count <= '0;
            r_s1        <= '0;
        end else begin
            r_row_count <= n_row_count;
            r_col_count <= n_col_count;
            r_s1        <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= line_mem[r_col_count];
        end
        if (s1_done) begin
            line_mem[r_s1.col] <= val;
        end
    end

    // stage 1: min-of-three update, write back, best tracking
    always_comb begin
        up     = (r_s1.row != '0) ? (r_s1.fwd ? r_wval : r_rdata) : '0;
        left   = (r_s1.col != '0) ? r_left_size : '0;
        diag   = (r_s1.row != '0 && r_s1.col != '0) ? r_diag_size : '0;
        min_ul = (up < left) ? up : left;
        min3   = (min_ul < diag) ? min_ul : diag;
        val    = r_s1.empty ? min3 + SZ_W'(1) : '0;

        n_best_side = r_best_side;
        n_best_top  = r_best_top;
        n_best_left = r_best_left;
        if (val > r_best_side) begin
            n_best_side = val;
            n_best_top  = POS_W'(SZ_W'(r_s1.row) + SZ_W'(1) - val);
            n_best_left = POS_W'(SZ_W'(r_s1.col) + SZ_W'(1) - val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            r_wval      <= val;
            r_left_size <= val;
            r_diag_size <= up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_side <= '0;
            r_best_top  <= '0;
            r_best_left <= '0;
        end else if (s1_done) begin
            if (r_s1.last) begin
                r_best_side <= '0;
                r_best_top  <= '0;
                r_best_left <= '0;
            end else begin
                r_best_side <= n_best_side;
                r_best_top  <= n_best_top;
                r_best_left <= n_best_left;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (s1_done && r_s1.last) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done && r_s1.last) begin
            r_found    <= (n_best_side != '0);
            r_res_size <= SIDE_W'(n_best_side);
            r_res_row  <= n_best_top;
            r_res_col  <= n_best_left;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_found     = r_found;
    assign o_best_size = r_res_size;
    assign o_best_row  = r_res_row;
    assign o_best_col  = r_res_col;

    a_best_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_done && r_s1.last |=> r_best_side == '0)
        else $error("best size not cleared after grid end");

    a_best_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_done && !r_s1.last |=> r_best_side >= $past(r_best_side))
        else $error("best size shrank within a grid");

    a_val_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid |-> val <= SZ_W'(r_s1.col) + SZ_W'(1)
                    && val <= SZ_W'(r_s1.row) + SZ_W'(1))
        else $error("square size exceeds its position");

    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> $stable(r_s1) && r_res_valid)
        else $error("stage moved during output stall");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Testbench: streams grids through the largest empty square finder and checks every result.
`timescale 1ns / 1ps

module testbench;
    import lesf_pkg::*;

    localparam int LAT_PAD      = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_ITEMS  = 120;

    localparam logic [APB_AW-1:0] ADDR_GRID_SIDE  = {REG_GRID_SIDE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_EMPTY_CODE = {REG_EMPTY_CODE, 2'b00};

    typedef struct packed {
        logic              found;
        logic [SIDE_W-1:0] size;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } t_square;

    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic [CODE_W-1:0] code;
        logic [3:0]        n_cells;
        logic [71:0]       cells;
        logic              typed;
        logic              found;
        logic [SIDE_W-1:0] size;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } t_grid_row;

    logic              i_clk;
    logic              i_rst_n          = 1'b0;
    logic              i_cell_req_valid = 1'b0;
    logic              o_cell_req_ready;
    logic [CODE_W-1:0] i_cell_req       = '0;
    logic              o_res_valid;
    logic              i_res_ready      = 1'b0;
    logic              o_found;
    logic [SIDE_W-1:0] o_best_size;
    logic [POS_W-1:0]  o_best_row;
    logic [POS_W-1:0]  o_best_col;
    logic              psel             = 1'b0;
    logic              penable          = 1'b0;
    logic              pwrite           = 1'b0;
    logic [APB_AW-1:0] paddr            = '0;
    logic [APB_DW-1:0] pwdata           = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    largest_empty_square_finder_top i_dut (.*);

    int      cfg_side;
    int      cfg_code;
    int      prev_sizes [MAX_SIDE];
    int      left_sz;
    int      diag_sz;
    int      row_cnt;
    int      col_cnt;
    int      best_side;
    int      best_top;
    int      best_left;
    t_square square_q [$];
    int      errors;
    int      items_sent;
    bit      gaps_on;
    bit      hold_req;

    t_grid_row grid_rows [8] = '{
        '{11'd0, 8'd46,  4'd1, 72'("."),         1'b1, 1'b1, 11'd1, 10'd0, 10'd0},
        '{11'd1, 8'd46,  4'd1, 72'("x"),         1'b1, 1'b0, 11'd0, 10'd0, 10'd0},
        '{11'd1, 8'd0,   4'd1, 72'h00,           1'b1, 1'b1, 11'd1, 10'd0, 10'd0},
        '{11'd1, 8'd255, 4'd1, 72'hff,           1'b1, 1'b1, 11'd1, 10'd0, 10'd0},
        '{11'd2, 8'd46,  4'd4, 72'("...."),      1'b1, 1'b1, 11'd2, 10'd0, 10'd0},
        '{11'd2, 8'd46,  4'd4, 72'("#..."),      1'b1, 1'b1, 11'd1, 10'd0, 10'd1},
        '{11'd3, 8'd46,  4'd9, 72'("#.......#"), 1'b1, 1'b1, 11'd2, 10'd0, 10'd1},
        '{11'd2, 8'd111, 4'd4, 72'("oo.o"),      1'b0, 1'b0, 11'd0, 10'd0, 10'd0}
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_search();
        left_sz   = 0;
        diag_sz   = 0;
        row_cnt   = 0;
        col_cnt   = 0;
        best_side = 0;
        best_top  = 0;
        best_left = 0;
    endfunction

    function automatic bit step_square_search(input int cell_byte, output t_square res);
        int side;
        int r;
        int c;
        int up;
        int lft;
        int dg;
        int val;
        side = cfg_side;
        if (side == 0) side = 1;
        if (side > MAX_SIDE) side = MAX_SIDE;
        r = row_cnt;
        c = col_cnt;
        if (c >= MAX_SIDE) c = MAX_SIDE - 1;
        up  = (r > 0) ? prev_sizes[c] : 0;
        lft = (c > 0) ? left_sz : 0;
        dg  = (r > 0 && c > 0) ? diag_sz : 0;
        val = 0;
        if (cell_byte == cfg_code) begin
            val = (up < lft) ? up : lft;
            if (dg < val) val = dg;
            val = val + 1;
        end
        diag_sz       = up;
        prev_sizes[c] = val;
        left_sz       = val;
        if (val > best_side) begin
            best_side = val;
            best_top  = r + 1 - val;
            best_left = c + 1 - val;
        end
        res = '0;
        if (c + 1 >= side && r + 1 >= side) begin
            res.found = (best_side > 0);
            res.size  = SIDE_W'(best_side);
            res.row   = POS_W'(best_top);
            res.col   = POS_W'(best_left);
            clear_search();
            return 1'b1;
        end
        if (c + 1 >= side) begin
            col_cnt = 0;
            row_cnt = r + 1;
            left_sz = 0;
            diag_sz = 0;
        end else begin
            col_cnt = c + 1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    task automatic apb_access(input bit wr, input logic [APB_AW-1:0] addr, input int wdata,
                              output logic [APB_DW-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= APB_DW'(wdata);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic [APB_AW-1:0] addr, input int want);
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, addr, 0, rd);
        if (rd !== APB_DW'(want)) report_mismatch("register readback", int'(rd), want);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input int value);
        logic [APB_DW-1:0] rd;
        apb_access(1'b1, addr, value, rd);
        if (addr == ADDR_GRID_SIDE) cfg_side = value;
        else cfg_code = value;
        check_reg(addr, value);
    endtask

    task automatic drain();
        i_cell_req_valid <= 1'b0;
        while (square_q.size() != 0) @(posedge i_clk);
        repeat (LAT_PAD) @(posedge i_clk);
    endtask

    task automatic send_cell(input int cell_byte, output bit done, output t_square res);
        if (gaps_on && $urandom_range(3) == 0) begin
            i_cell_req_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
        // hold valid and payload until the transfer
        i_cell_req_valid <= 1'b1;
        i_cell_req       <= CODE_W'(cell_byte);
        do @(posedge i_clk); while (!o_cell_req_ready);
        items_sent++;
        done = step_square_search(cell_byte, res);
    endtask

    task automatic run_grid(input int density, input int shrink_at, input int new_side);
        int      sent;
        int      cell_byte;
        bit      done;
        t_square res;
        sent = 0;
        done = 1'b0;
        while (!done) begin
            if (sent == shrink_at) begin
                drain();
                write_reg(ADDR_GRID_SIDE, new_side);
            end
            cell_byte = ($urandom_range(99) < density) ? cfg_code : $urandom_range(255);
            send_cell(cell_byte, done, res);
            sent++;
        end
        square_q.push_back(res);
    endtask

    initial begin
        int      quiet;
        t_square want;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            quiet++;
            if ((i_cell_req_valid && o_cell_req_ready) || (psel && penable)) quiet = 0;
            if (o_res_valid && i_res_ready) begin
                quiet = 0;
                if (square_q.size() == 0) begin
                    report_mismatch("unexpected result, size", int'(o_best_size), 0);
                end else begin
                    want = square_q.pop_front();
                    if (o_found !== want.found)
                        report_mismatch("found", int'(o_found), int'(want.found));
                    if (o_best_size !== want.size)
                        report_mismatch("best_size", int'(o_best_size), int'(want.size));
                    if (o_best_row !== want.row)
                        report_mismatch("best_row", int'(o_best_row), int'(want.row));
                    if (o_best_col !== want.col)
                        report_mismatch("best_col", int'(o_best_col), int'(want.col));
                end
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (gaps_on && $urandom_range(5) == 0) begin
                i_res_ready <= 1'b0;
                repeat ($urandom_range(8, 1)) @(posedge i_clk);
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    initial begin
        int      base;
        int      side;
        int      density;
        int      shrink_at;
        int      new_side;
        int      sel;
        bit      pressed;
        bit      done;
        t_square res;
        errors     = 0;
        items_sent = 0;
        gaps_on    = 1'b1;
        hold_req   = 1'b0;
        pressed    = 1'b0;
        cfg_side   = int'(SIDE_RESET);
        cfg_code   = int'(EMPTY_RESET);
        clear_search();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_reg(ADDR_GRID_SIDE, int'(SIDE_RESET));
        check_reg(ADDR_EMPTY_CODE, int'(EMPTY_RESET));
        run_grid(80, 5, 1);

        for (int k = 0; k < 8; k++) begin
            drain();
            write_reg(ADDR_GRID_SIDE, int'(grid_rows[k].side));
            write_reg(ADDR_EMPTY_CODE, int'(grid_rows[k].code));
            for (int i = 0; i < int'(grid_rows[k].n_cells); i++)
                send_cell(int'(grid_rows[k].cells[8*(int'(grid_rows[k].n_cells)-1-i) +: 8]),
                          done, res);
            if (grid_rows[k].typed)
                res = '{grid_rows[k].found, grid_rows[k].size, grid_rows[k].row,
                        grid_rows[k].col};
            square_q.push_back(res);
        end

        // oversized side, then shrink mid-grid
        drain();
        write_reg(ADDR_GRID_SIDE, 2047);
        write_reg(ADDR_EMPTY_CODE, 46);
        run_grid(90, 6, 2);
        drain();
        write_reg(ADDR_GRID_SIDE, MAX_SIDE);
        run_grid(50, 10, 1);

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            drain();
            gaps_on = (items_sent - base < RANDOM_ITEMS - QUIET_ITEMS) &&
                      ($urandom_range(4) != 0);
            if (!pressed && items_sent - base > RANDOM_ITEMS / 2) begin
                // stall the result side while cells keep coming
                pressed = 1'b1;
                write_reg(ADDR_GRID_SIDE, 1);
                hold_req = 1'b1;
                repeat (24) run_grid(50, -1, 0);
                drain();
            end
            sel = $urandom_range(99);
            if (sel < 70) side = $urandom_range(6, 1);
            else if (sel < 95) side = $urandom_range(20, 7);
            else side = $urandom_range(32, 21);
            write_reg(ADDR_GRID_SIDE, side);
            write_reg(ADDR_EMPTY_CODE, $urandom_range(1) ? 46 : $urandom_range(255));
            density = ($urandom_range(9) < 7) ? $urandom_range(100, 60) : $urandom_range(100);
            shrink_at = -1;
            new_side  = 0;
            if (side >= 2 && $urandom_range(6) == 0) begin
                shrink_at = $urandom_range(side * side - 2, 1);
                new_side  = $urandom_range(side - 1, 1);
            end
            run_grid(density, shrink_at, new_side);
        end
        drain();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
